/* src/rpn_stack_calculator_unit_macros.svh */
// ----------------------------------------------------------------------------
// RPN stack calculator assertion macros
// Shared concurrent assertion forms, clocked on clk_i and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_UNIT_MACROS_SVH
`define RPN_STACK_CALCULATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rsc_pkg.sv */
// ----------------------------------------------------------------------------
// RPN stack calculator package
// Shared constants, item types, ALU codes and control structs.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int CHAR_W          = 8;
  localparam int OUT_VALUE_W     = 32;
  localparam int STATUS_W        = 2;

  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_VALUE_W-1:0] value;
    logic [STATUS_W-1:0]           status;
  } out_item_t;

endpackage

/* src/rsc_stream_if.sv */
// ----------------------------------------------------------------------------
// RPN stack calculator stream interface
// Valid/ready channel carrying one item of payload type T.
// ----------------------------------------------------------------------------
interface rsc_stream_if #(
  parameter type T = logic
);

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

/* src/rsc_ram.sv */
// ----------------------------------------------------------------------------
// RPN stack calculator RAM
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/rsc_alu.sv */
// ----------------------------------------------------------------------------
// RPN stack calculator serial ALU
// Add and subtract one bit per cycle through a carry flop; multiply and
// divide retire one operand bit per cycle by shift-add and restoring steps.
// ----------------------------------------------------------------------------
module rsc_alu
  import rsc_pkg::*;
#(
  parameter int W = VALUE_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  alu_ctrl_t    ctrl_i,
  input  logic [W-1:0] l_i,
  input  logic [W-1:0] r_i,
  output alu_stat_t    stat_o,
  output logic [W-1:0] result_o
);

  localparam int CNT_W = $clog2(W);

  typedef enum logic [2:0] {
    A_IDLE,
    A_PREP,
    A_RUN,
    A_FIX,
    A_DONE
  } alu_state_e;

  alu_state_e       state_q, state_d;
  alu_op_e          op_q, op_d;
  logic [W-1:0]     a_q, a_d;
  logic [W-1:0]     b_q, b_d;
  logic [W-1:0]     acc_q, acc_d;
  logic [W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             carry_q, carry_d;
  logic             neg_q, neg_d;

  logic             b_bit;
  logic             sum_bit;
  logic [W:0]       rem_sh;
  logic [W+1:0]     diff;
  logic             ge;

  always_comb begin
    b_bit   = b_q[0] ^ (op_q == ALU_SUB);
    sum_bit = a_q[0] ^ b_bit ^ carry_q;
    rem_sh  = {rem_q, a_q[W-1]};
    diff    = {1'b0, rem_sh} - {2'b00, b_q};
    ge      = ~diff[W+1];
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    carry_d = carry_q;
    neg_d   = neg_q;

    unique case (state_q)
      A_IDLE: begin
        if (ctrl_i.start) begin
          op_d    = ctrl_i.op;
          a_d     = l_i;
          b_d     = r_i;
          acc_d   = '0;
          rem_d   = '0;
          cnt_d   = '0;
          carry_d = (ctrl_i.op == ALU_SUB);
          neg_d   = l_i[W-1] ^ r_i[W-1];
          state_d = (ctrl_i.op == ALU_DIV) ? A_PREP : A_RUN;
        end
      end
      A_PREP: begin
        // Divide works on magnitudes; the sign is restored afterwards.
        a_d     = a_q[W-1] ? (W'(0) - a_q) : a_q;
        b_d     = b_q[W-1] ? (W'(0) - b_q) : b_q;
        state_d = A_RUN;
      end
      A_RUN: begin
        case (op_q)
          ALU_ADD, ALU_SUB: begin
            acc_d   = {sum_bit, acc_q[W-1:1]};
            carry_d = (a_q[0] & b_bit) | (a_q[0] & carry_q) | (b_bit & carry_q);
            a_d     = a_q >> 1;
            b_d     = b_q >> 1;
          end
          ALU_MUL: begin
            if (b_q[0]) begin
              acc_d = acc_q + a_q;
            end
            a_d = a_q << 1;
            b_d = b_q >> 1;
          end
          default: begin
            // Restoring step: the quotient bit shifts into the dividend register.
            rem_d = ge ? diff[W-1:0] : rem_sh[W-1:0];
            a_d   = {a_q[W-2:0], ge};
          end
        endcase
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(W - 1)) begin
          state_d = (op_q == ALU_DIV) ? A_FIX : A_DONE;
        end
      end
      A_FIX: begin
        acc_d   = neg_q ? (W'(0) - a_q) : a_q;
        state_d = A_DONE;
      end
      A_DONE: begin
        state_d = A_IDLE;
      end
      default: begin
        state_d = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      op_q    <= ALU_ADD;
      a_q     <= '0;
      b_q     <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      carry_q <= 1'b0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      a_q     <= a_d;
      b_q     <= b_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      carry_q <= carry_d;
      neg_q   <= neg_d;
    end
  end

  assign stat_o.busy = (state_q != A_IDLE);
  assign stat_o.done = (state_q == A_DONE);
  assign result_o    = acc_q;

endmodule

/* src/rpn_stack_calculator_unit.sv */
// ----------------------------------------------------------------------------
// RPN stack calculator
// Evaluates a reverse Polish expression one ASCII character per item on a
// stack held in RAM, with a bit-serial ALU for + - * /.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload                Meaning
//  char_i   in         character[7:0]         one ASCII character
//  res_o    out        value[31:0], status[1:0]  popped value or error code
//
// Digits and ignored characters are handled in the idle state; an overflow or
// underflow error passes through S_EMIT, and '=' through S_POP and S_EMIT.
// + - * / pass through S_RD_L, S_START and S_ALU on the one-bit-per-cycle
// shift-register ALU; a zero divisor skips the ALU and reports from S_START.
// A result waits in an output register; a new character is taken while it
// waits, and only a further result stalls until the register drains.
// Reset empties the stack; the stack RAM itself is not cleared.
// ----------------------------------------------------------------------------
`include "rpn_stack_calculator_unit_macros.svh"

module rpn_stack_calculator_unit
  import rsc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsc_stream_if.sink   char_i,
  rsc_stream_if.source res_o
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_L,
    S_START,
    S_ALU,
    S_POP,
    S_EMIT
  } state_e;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  alu_op_e                 op_q, op_d;
  logic [VALUE_WIDTH-1:0]  r_q, r_d;
  logic [OUT_VALUE_W-1:0]  pend_value_q, pend_value_d;
  status_e                 pend_status_q, pend_status_d;
  logic                    res_valid_q, res_valid_d;
  out_item_t               res_data_q, res_data_d;

  logic                    in_acc;
  logic [CHAR_W-1:0]       ch;
  logic                    ch_digit;
  logic                    op_go;
  logic [CNT_W-1:0]        cnt_m1;
  logic [CNT_W-1:0]        cnt_m2;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [VALUE_WIDTH-1:0]  ram_wdata;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [VALUE_WIDTH-1:0]  ram_rdata;

  alu_ctrl_t               alu_ctrl;
  alu_stat_t               alu_stat;
  logic [VALUE_WIDTH-1:0]  alu_result;

  assign in_acc   = char_i.valid && char_i.ready;
  assign ch       = char_i.data.character;
  assign ch_digit = (ch >= CH_0) && (ch <= CH_9);
  assign cnt_m1   = count_q - CNT_W'(1);
  assign cnt_m2   = count_q - CNT_W'(2);
  assign ram_raddr = (state_q == S_RD_L) ? cnt_m2[ADDR_W-1:0] : cnt_m1[ADDR_W-1:0];

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    op_d          = op_q;
    r_d           = r_q;
    pend_value_d  = pend_value_q;
    pend_status_d = pend_status_q;
    res_valid_d   = res_valid_q && !res_o.ready;
    res_data_d    = res_data_q;
    ram_we        = 1'b0;
    ram_waddr     = count_q[ADDR_W-1:0];
    ram_wdata     = VALUE_WIDTH'(ch - CH_0);
    alu_ctrl.start = 1'b0;
    alu_ctrl.op    = op_q;
    op_go         = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (ch_digit) begin
            if (count_q == CNT_W'(STACK_DEPTH)) begin
              pend_value_d  = '0;
              pend_status_d = ST_OVER;
              state_d       = S_EMIT;
            end else begin
              ram_we  = 1'b1;
              count_d = count_q + CNT_W'(1);
            end
          end else begin
            case (ch)
              CH_PLUS: begin
                op_d  = ALU_ADD;
                op_go = 1'b1;
              end
              CH_MINUS: begin
                op_d  = ALU_SUB;
                op_go = 1'b1;
              end
              CH_STAR: begin
                op_d  = ALU_MUL;
                op_go = 1'b1;
              end
              CH_SLASH: begin
                op_d  = ALU_DIV;
                op_go = 1'b1;
              end
              CH_EQUAL: begin
                if (count_q == '0) begin
                  pend_value_d  = '0;
                  pend_status_d = ST_UNDER;
                  state_d       = S_EMIT;
                end else begin
                  state_d = S_POP;
                end
              end
              CH_SPACE: begin
              end
              default: begin
              end
            endcase
            if (op_go) begin
              if (count_q < CNT_W'(2)) begin
                pend_value_d  = '0;
                pend_status_d = ST_UNDER;
                state_d       = S_EMIT;
              end else begin
                state_d = S_RD_L;
              end
            end
          end
        end
      end
      S_RD_L: begin
        // The right operand read at accept time is on the RAM output now.
        r_d     = ram_rdata;
        state_d = S_START;
      end
      S_START: begin
        if ((op_q == ALU_DIV) && (r_q == '0)) begin
          pend_value_d  = '0;
          pend_status_d = ST_DIVZ;
          state_d       = S_EMIT;
        end else begin
          alu_ctrl.start = 1'b1;
          state_d        = S_ALU;
        end
      end
      S_ALU: begin
        if (alu_stat.done) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_m2[ADDR_W-1:0];
          ram_wdata = alu_result;
          count_d   = cnt_m1;
          state_d   = S_IDLE;
        end
      end
      S_POP: begin
        pend_value_d  = OUT_VALUE_W'($signed(ram_rdata));
        pend_status_d = ST_OK;
        count_d       = cnt_m1;
        state_d       = S_EMIT;
      end
      S_EMIT: begin
        if (!res_valid_q || res_o.ready) begin
          res_valid_d       = 1'b1;
          res_data_d.value  = pend_value_q;
          res_data_d.status = pend_status_q;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      op_q          <= ALU_ADD;
      r_q           <= '0;
      pend_value_q  <= '0;
      pend_status_q <= ST_OK;
      res_valid_q   <= 1'b0;
      res_data_q    <= '0;
    end else begin
      state_q       <= state_d;
      count_q       <= count_d;
      op_q          <= op_d;
      r_q           <= r_d;
      pend_value_q  <= pend_value_d;
      pend_status_q <= pend_status_d;
      res_valid_q   <= res_valid_d;
      res_data_q    <= res_data_d;
    end
  end

  assign char_i.ready = (state_q == S_IDLE);
  assign res_o.valid  = res_valid_q;
  assign res_o.data   = res_data_q;

  rsc_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rsc_alu #(
    .W (VALUE_WIDTH)
  ) u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (alu_ctrl),
    .l_i      (ram_rdata),
    .r_i      (r_q),
    .stat_o   (alu_stat),
    .result_o (alu_result)
  );

  `RSC_ASSERT_NEXT(a_alu_pops_one, (state_q == S_ALU) && alu_stat.done, count_q == ($past(count_q) - CNT_W'(1)), "operator completion did not drop the stack by one")
  `RSC_ASSERT_NEXT(a_full_push_errors, in_acc && ch_digit && (count_q == CNT_W'(STACK_DEPTH)), (state_q == S_EMIT) && (pend_status_q == ST_OVER), "push to a full stack did not raise overflow")
  `RSC_ASSERT_SAME(a_alu_owned, state_q != S_ALU, !alu_stat.busy, "ALU busy while the controller is not waiting on it")

endmodule
